@@ rtl/core/bgd_pkg.sv @@
// types, constants and helpers shared by the button gesture detector
// no dependencies
package bgd_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SPAN_BITS   = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SELECT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SENSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd5;

  // gesture modes, the reserved code acts as press
  localparam logic [1:0] MODE_FLICK = 2'd0;
  localparam logic [1:0] MODE_PRESS = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;

  localparam logic SRC_ANALOG  = 1'b0;
  localparam logic SRC_DIGITAL = 1'b1;

  // phase codes as seen on the result
  localparam logic [1:0] PHASE_CODE_WAIT_ACTIVE  = 2'd0;
  localparam logic [1:0] PHASE_CODE_WAIT_HOLD    = 2'd1;
  localparam logic [1:0] PHASE_CODE_WAIT_RELEASE = 2'd2;
  localparam logic [1:0] PHASE_CODE_DEBOUNCE     = 2'd3;

  typedef enum logic [3:0] {
    PH_WAIT_ACTIVE  = 4'b0001,
    PH_WAIT_HOLD    = 4'b0010,
    PH_WAIT_RELEASE = 4'b0100,
    PH_DEBOUNCE     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]             gesture_mode;
    logic                   source_select;
    logic [SAMPLE_BITS-1:0] level_threshold;
    logic                   invert_sense;
    logic [SPAN_BITS-1:0]   hold_ms;
    logic [SPAN_BITS-1:0]   debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] analog_level;
    logic                   digital_level;
    logic [TIME_BITS-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] phase;
  } out_item_t;

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_WAIT_ACTIVE:  code = PHASE_CODE_WAIT_ACTIVE;
      PH_WAIT_HOLD:    code = PHASE_CODE_WAIT_HOLD;
      PH_WAIT_RELEASE: code = PHASE_CODE_WAIT_RELEASE;
      PH_DEBOUNCE:     code = PHASE_CODE_DEBOUNCE;
      default:         code = PHASE_CODE_WAIT_ACTIVE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/bgd_stream_if.sv @@
// valid/ready channel interfaces for poll requests and gesture results
// depends on bgd_pkg
interface bgd_req_if import bgd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] analog_level;
  logic                   digital_level;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, output analog_level, output digital_level, output now_ms,
                  input ready);
  modport sink (input valid, input analog_level, input digital_level, input now_ms,
                output ready);
endinterface

interface bgd_res_if import bgd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       fire;
  logic [1:0] phase;

  modport source (output valid, output fire, output phase, input ready);
  modport sink (input valid, input fire, input phase, output ready);
endinterface

@@ rtl/core/bgd_cfg_regs.sv @@
// configuration register file of the gesture detector
// depends on bgd_pkg
module bgd_cfg_regs import bgd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GESTURE_MODE:    cfg_d.gesture_mode    = cfg_wdata_i[1:0];
        CFG_SOURCE_SELECT:   cfg_d.source_select   = cfg_wdata_i[0];
        CFG_LEVEL_THRESHOLD: cfg_d.level_threshold = cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_INVERT_SENSE:    cfg_d.invert_sense    = cfg_wdata_i[0];
        CFG_HOLD_MS:         cfg_d.hold_ms         = cfg_wdata_i[SPAN_BITS-1:0];
        CFG_DEBOUNCE_MS:     cfg_d.debounce_ms     = cfg_wdata_i[SPAN_BITS-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gesture_mode    <= MODE_PRESS;
      cfg_q.source_select   <= SRC_DIGITAL;
      cfg_q.level_threshold <= SAMPLE_BITS'(512);
      cfg_q.invert_sense    <= 1'b0;
      cfg_q.hold_ms         <= SPAN_BITS'(500);
      cfg_q.debounce_ms     <= SPAN_BITS'(50);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/bgd_gesture_core.sv @@
// active test, gesture phase machine and deadline register
// depends on bgd_pkg
module bgd_gesture_core import bgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      advance_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic [TIME_BITS-1:0] hold_deadline, deb_deadline, since;
  logic                 active, reached, is_flick, is_hold, fire;

  always_comb begin
    if (cfg_i.source_select == SRC_DIGITAL) begin
      active = cfg_i.invert_sense ? !item_i.digital_level : item_i.digital_level;
    end else begin
      active = cfg_i.invert_sense ? (item_i.analog_level < cfg_i.level_threshold)
                                  : (item_i.analog_level > cfg_i.level_threshold);
    end
  end

  assign hold_deadline = item_i.now_ms + TIME_BITS'(cfg_i.hold_ms);
  assign deb_deadline  = item_i.now_ms + TIME_BITS'(cfg_i.debounce_ms);
  // wrap-safe now >= deadline
  assign since   = item_i.now_ms - deadline_q;
  assign reached = !since[TIME_BITS-1];

  assign is_flick = (cfg_i.gesture_mode == MODE_FLICK);
  assign is_hold  = (cfg_i.gesture_mode == MODE_HOLD);

  always_comb begin
    phase_d    = phase_q;
    deadline_d = deadline_q;
    fire       = 1'b0;
    case (phase_q)
      PH_WAIT_ACTIVE: begin
        if (active) begin
          deadline_d = hold_deadline;
          phase_d    = is_flick ? PH_WAIT_RELEASE : PH_WAIT_HOLD;
        end
      end
      PH_WAIT_HOLD, PH_WAIT_RELEASE: begin
        if (is_flick) begin
          // flick: a release before the deadline fires, a timeout does not
          if (reached) begin
            deadline_d = deb_deadline;
            phase_d    = PH_DEBOUNCE;
          end else if (!active) begin
            deadline_d = deb_deadline;
            phase_d    = PH_DEBOUNCE;
            fire       = 1'b1;
          end
        end else if (phase_q == PH_WAIT_HOLD) begin
          if (!active) begin
            deadline_d = deb_deadline;
            phase_d    = PH_DEBOUNCE;
          end else if (reached) begin
            if (is_hold) begin
              deadline_d = deb_deadline;
              phase_d    = PH_DEBOUNCE;
              fire       = 1'b1;
            end else begin
              phase_d = PH_WAIT_RELEASE;
            end
          end
        end else if (!active) begin
          deadline_d = deb_deadline;
          phase_d    = PH_DEBOUNCE;
          fire       = !is_hold;
        end
      end
      PH_DEBOUNCE: begin
        if (!active && reached) begin
          phase_d = PH_WAIT_ACTIVE;
        end
      end
      default: begin
        phase_d = PH_WAIT_ACTIVE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT_ACTIVE;
      deadline_q <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
    end
  end

  assign res_o.fire  = fire;
  assign res_o.phase = phase_code(phase_d);

endmodule

@@ rtl/core/button_gesture_detector_unit.sv @@
// top level of the button gesture detector: config registers, request register, core, result register
// depends on bgd_pkg, bgd_stream_if, bgd_cfg_regs, bgd_gesture_core
//
//   channel  dir  fields                                 accepted when
//   req_i    in   analog_level, digital_level, now_ms    valid && ready
//   res_o    out  fire, phase                            valid && ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                 cfg_we_i
//
// one poll per cycle sustained while results are taken; a taken request passes
// through the request register, which loads on the accepting edge, and then the
// result register, fed by the phase machine when the request advances
// reset returns the machine to wait active with a zero deadline and the
// configuration registers to their defaults; no clearing pass
// a stalled result holds its register; the request register still takes a
// request and waits behind it, so ready drops only when both stages are full
module button_gesture_detector_unit import bgd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bgd_req_if.sink               req_i,
  bgd_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t core_res, out_item_q;
  logic      out_valid_q;
  logic      advance, take_req;

  bgd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the registered request moves into the result stage and updates state
  assign advance   = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign take_req  = req_i.valid && req_i.ready;

  bgd_gesture_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .res_o     (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_req) begin
      s1_item_q.analog_level  <= req_i.analog_level;
      s1_item_q.digital_level <= req_i.digital_level;
      s1_item_q.now_ms        <= req_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= core_res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.fire  = out_item_q.fire;
  assign res_o.phase = out_item_q.phase;

  // every gesture that fires goes straight into debounce
  a_fire_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.fire) |-> (res_o.phase == PHASE_CODE_DEBOUNCE))
    else $error("fire without debounce phase");

  // a request that moves on always lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request lost");

  // a request held behind a stalled result is not dropped
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("stalled request lost");

  // the request side never overruns a full pipeline
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !res_o.ready) |-> !req_i.ready)
    else $error("request taken into full pipeline");

endmodule
